// ===== design/rrsbc_pkg.sv =====
// shared types and constants for the random replacement size budget cache
package rrsbc_pkg;

	localparam int ENTRIES_DEF = 32;
	localparam logic [15:0] LFSR_SEED = 16'hACE1;
	localparam logic [23:0] CAP_RESET = 24'hFFFFFF;
	localparam logic [15:0] TALLY_MAX = 16'hFFFF;

	localparam logic [1:0] ACT_LOOKUP = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_DELETE = 2'd2;
	localparam logic [1:0] ACT_CLEAR  = 2'd3;

	localparam logic [2:0] KIND_LOOKUP = 3'd0;
	localparam logic [2:0] KIND_EVICT  = 3'd1;
	localparam logic [2:0] KIND_INSERT = 3'd2;
	localparam logic [2:0] KIND_DELETE = 3'd3;
	localparam logic [2:0] KIND_CLEAR  = 3'd4;
	localparam logic [2:0] KIND_ERROR  = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_COMPARE,
		ST_DECIDE,
		ST_EV_CHECK,
		ST_EV_MOD,
		ST_RM_RD,
		ST_RM_CAP,
		ST_SH_RD,
		ST_SH_WR,
		ST_APPEND,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic start;
		logic [15:0] dividend;
	} mod_req_t;

endpackage

// ===== design/rrsbc_mod_unit.sv =====
// restoring remainder unit, one quotient bit per cycle
module rrsbc_mod_unit #(
	parameter int IDX_W = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rrsbc_pkg::mod_req_t  req,
	input  logic [IDX_W-1:0]     divisor,
	output logic                 done,
	output logic [IDX_W-1:0]     remainder
);
	logic [15:0]      quo_q;
	logic [IDX_W-1:0] rem_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [IDX_W:0]   trial;
	logic [IDX_W:0]   dext;

	assign dext  = {1'b0, divisor};
	assign trial = {rem_q, quo_q[15]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[14:0], 1'b0};
			if (trial >= dext)
				rem_q <= IDX_W'(trial - dext);
			else
				rem_q <= trial[IDX_W-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;
endmodule

// ===== design/random_replacement_size_budget_cache_unit.sv =====
// top level: directory memories, sequencer, remainder unit for eviction
// every item first searches the stored entries; deleting a stored key removes it and
// inserting a new key appends it, evicting first while it does not fit; each eviction
// picks a victim with the remainder unit and shifts the later entries down by one
// throughput: one item at a time, in_ready only while idle; a held result stalls the sequencer
// reset: asynchronous active low clears entries, total, counters; capacity to max; seeds lfsr
module random_replacement_size_budget_cache_unit #(
	parameter int ENTRIES = rrsbc_pkg::ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [31:0] video_id,
	input  logic [15:0] segment_id,
	input  logic [15:0] segment_size,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic        hit,
	output logic [31:0] out_video_id,
	output logic [15:0] out_segment_id,
	output logic [23:0] occupied_size,
	output logic [5:0]  stored_entries,
	output logic [15:0] reads_done,
	output logic [15:0] writes_done,
	output logic        final_item
);
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);

	rrsbc_pkg::state_t state_q, state_d;

	logic [47:0] key_mem [ENTRIES];
	logic [15:0] size_mem [ENTRIES];

	logic [23:0] cap_q;
	logic [CNT_W-1:0] count_q;
	logic [23:0] used_q;
	logic [15:0] lfsr_q;
	logic [15:0] rd_q, wr_q;
	logic [CNT_W-1:0] ptr_q;
	logic        found_q;
	logic        out_valid_q;

	logic [1:0]  act_q;
	logic [47:0] key_q;
	logic [15:0] size_q;
	logic [47:0] rkey_q;
	logic [15:0] rsize_q;
	logic [47:0] victim_q;

	logic [2:0]  o_kind_q;
	logic        o_hit_q;
	logic [47:0] o_key_q;
	logic        o_fin_q;

	// outputs registered at emit
	logic [2:0]  ok_q;
	logic        oh_q, of_q;
	logic [47:0] okey_q;
	logic [23:0] ou_q;
	logic [CNT_W-1:0] oc_q;
	logic [15:0] ord_q, owr_q;

	rrsbc_pkg::mod_req_t mreq;
	logic        mdone;
	logic [CNT_W-1:0] mrem;
	logic [15:0] lfsr_nx;
	logic [CNT_W-1:0] ptr_inc;
	logic        ptr_end;
	logic        shift_end;
	logic        key_match;
	logic        too_big;
	logic        emit_go;
	logic [24:0] need;
	logic        must_evict;
	logic [IDX_W-1:0] rd_idx;

	assign lfsr_nx = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
	assign ptr_inc = ptr_q + CNT_W'(1);
	assign ptr_end = (ptr_q >= count_q);
	assign shift_end = (ptr_inc >= count_q);
	assign key_match = (rkey_q == key_q);
	assign too_big = ({8'd0, size_q} > cap_q);
	assign emit_go = !out_valid_q || out_ready;
	assign need = {1'b0, used_q} + {9'd0, size_q};
	assign must_evict = (count_q != '0) &&
		((need > {1'b0, cap_q}) || (count_q >= CNT_W'(ENTRIES)));

	rrsbc_mod_unit #(.IDX_W(CNT_W)) u_mod (
		.clk(clk), .arst_n(arst_n), .req(mreq), .divisor(count_q),
		.done(mdone), .remainder(mrem)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			rrsbc_pkg::ST_IDLE:
				if (in_valid) state_d = rrsbc_pkg::ST_SEARCH;
			rrsbc_pkg::ST_SEARCH:
				state_d = ptr_end ? rrsbc_pkg::ST_DECIDE : rrsbc_pkg::ST_COMPARE;
			rrsbc_pkg::ST_COMPARE:
				state_d = key_match ? rrsbc_pkg::ST_DECIDE : rrsbc_pkg::ST_SEARCH;
			rrsbc_pkg::ST_DECIDE: begin
				if (act_q == rrsbc_pkg::ACT_DELETE && found_q)
					state_d = rrsbc_pkg::ST_RM_RD;
				else if (act_q == rrsbc_pkg::ACT_INSERT && !found_q && !too_big)
					state_d = rrsbc_pkg::ST_EV_CHECK;
				else
					state_d = rrsbc_pkg::ST_EMIT;
			end
			rrsbc_pkg::ST_EV_CHECK:
				state_d = must_evict ? rrsbc_pkg::ST_EV_MOD : rrsbc_pkg::ST_APPEND;
			rrsbc_pkg::ST_EV_MOD:
				if (mdone) state_d = rrsbc_pkg::ST_RM_RD;
			rrsbc_pkg::ST_RM_RD:
				state_d = rrsbc_pkg::ST_RM_CAP;
			rrsbc_pkg::ST_RM_CAP:
				state_d = rrsbc_pkg::ST_SH_RD;
			rrsbc_pkg::ST_SH_RD:
				state_d = shift_end ? rrsbc_pkg::ST_EMIT : rrsbc_pkg::ST_SH_WR;
			rrsbc_pkg::ST_SH_WR:
				state_d = rrsbc_pkg::ST_SH_RD;
			rrsbc_pkg::ST_APPEND:
				state_d = rrsbc_pkg::ST_EMIT;
			rrsbc_pkg::ST_EMIT:
				if (emit_go) state_d = o_fin_q ? rrsbc_pkg::ST_IDLE : rrsbc_pkg::ST_EV_CHECK;
			default: state_d = rrsbc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == rrsbc_pkg::ST_IDLE);
		mreq.start = (state_q == rrsbc_pkg::ST_EV_CHECK) && must_evict;
		mreq.dividend = lfsr_nx;
	end

	// memory port: read at ptr, shift reads ptr+1 and writes it back at ptr
	assign rd_idx = (state_q == rrsbc_pkg::ST_SH_RD) ? ptr_inc[IDX_W-1:0]
		: ptr_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		rkey_q  <= key_mem[rd_idx];
		rsize_q <= size_mem[rd_idx];
		if (state_q == rrsbc_pkg::ST_APPEND) begin
			key_mem[count_q[IDX_W-1:0]]  <= key_q;
			size_mem[count_q[IDX_W-1:0]] <= size_q;
		end else if (state_q == rrsbc_pkg::ST_SH_WR) begin
			key_mem[ptr_q[IDX_W-1:0]]  <= rkey_q;
			size_mem[ptr_q[IDX_W-1:0]] <= rsize_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrsbc_pkg::ST_IDLE;
			cap_q   <= rrsbc_pkg::CAP_RESET;
			count_q <= '0;
			used_q  <= '0;
			lfsr_q  <= rrsbc_pkg::LFSR_SEED;
			rd_q    <= '0;
			wr_q    <= '0;
			ptr_q   <= '0;
			found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) cap_q <= cfg_wdata;
			if (state_q == rrsbc_pkg::ST_EMIT && emit_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				rrsbc_pkg::ST_IDLE:
					if (in_valid) begin
						ptr_q   <= '0;
						found_q <= 1'b0;
					end
				rrsbc_pkg::ST_COMPARE: begin
					if (key_match)
						found_q <= 1'b1;
					else
						ptr_q <= ptr_inc;
				end
				rrsbc_pkg::ST_DECIDE: begin
					if (act_q == rrsbc_pkg::ACT_LOOKUP && rd_q != rrsbc_pkg::TALLY_MAX)
						rd_q <= rd_q + 16'd1;
					if (act_q == rrsbc_pkg::ACT_CLEAR) begin
						rd_q <= '0;
						wr_q <= '0;
					end
				end
				rrsbc_pkg::ST_EV_CHECK:
					if (must_evict) lfsr_q <= lfsr_nx;
				rrsbc_pkg::ST_EV_MOD:
					if (mdone) ptr_q <= mrem;
				rrsbc_pkg::ST_RM_CAP:
					used_q <= used_q - {8'd0, rsize_q};
				rrsbc_pkg::ST_SH_RD:
					if (shift_end) begin
						count_q <= count_q - CNT_W'(1);
						if (act_q == rrsbc_pkg::ACT_DELETE && wr_q != rrsbc_pkg::TALLY_MAX)
							wr_q <= wr_q + 16'd1;
					end
				rrsbc_pkg::ST_SH_WR:
					ptr_q <= ptr_inc;
				rrsbc_pkg::ST_APPEND: begin
					count_q <= count_q + CNT_W'(1);
					used_q  <= used_q + {8'd0, size_q};
					if (wr_q != rrsbc_pkg::TALLY_MAX)
						wr_q <= wr_q + 16'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rrsbc_pkg::ST_IDLE && in_valid) begin
			act_q  <= action;
			key_q  <= {video_id, segment_id};
			size_q <= segment_size;
		end
		if (state_q == rrsbc_pkg::ST_RM_CAP)
			victim_q <= rkey_q;
		case (state_q)
			rrsbc_pkg::ST_DECIDE: begin
				o_key_q <= key_q;
				o_fin_q <= 1'b1;
				case (act_q)
					rrsbc_pkg::ACT_LOOKUP: begin
						o_kind_q <= rrsbc_pkg::KIND_LOOKUP;
						o_hit_q  <= found_q;
					end
					rrsbc_pkg::ACT_CLEAR: begin
						o_kind_q <= rrsbc_pkg::KIND_CLEAR;
						o_hit_q  <= 1'b0;
					end
					rrsbc_pkg::ACT_DELETE: begin
						o_kind_q <= rrsbc_pkg::KIND_ERROR;
						o_hit_q  <= 1'b0;
					end
					default: begin
						o_kind_q <= too_big ? rrsbc_pkg::KIND_ERROR : rrsbc_pkg::KIND_INSERT;
						o_hit_q  <= !too_big && found_q;
					end
				endcase
			end
			rrsbc_pkg::ST_SH_RD:
				if (shift_end) begin
					o_kind_q <= (act_q == rrsbc_pkg::ACT_DELETE) ? rrsbc_pkg::KIND_DELETE
						: rrsbc_pkg::KIND_EVICT;
					o_hit_q  <= (act_q == rrsbc_pkg::ACT_DELETE);
					o_key_q  <= victim_q;
					o_fin_q  <= (act_q == rrsbc_pkg::ACT_DELETE);
				end
			rrsbc_pkg::ST_APPEND: begin
				o_kind_q <= rrsbc_pkg::KIND_INSERT;
				o_hit_q  <= 1'b0;
				o_key_q  <= key_q;
				o_fin_q  <= 1'b1;
			end
			default: ;
		endcase
		if (state_q == rrsbc_pkg::ST_EMIT && emit_go) begin
			ok_q   <= o_kind_q;
			oh_q   <= o_hit_q;
			of_q   <= o_fin_q;
			okey_q <= o_key_q;
			ou_q   <= used_q;
			oc_q   <= count_q;
			ord_q  <= rd_q;
			owr_q  <= wr_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = ok_q;
	assign hit            = oh_q;
	assign final_item     = of_q;
	assign out_video_id   = okey_q[47:16];
	assign out_segment_id = okey_q[15:0];
	assign occupied_size  = ou_q;
	assign stored_entries = 6'(oc_q);
	assign reads_done     = ord_q;
	assign writes_done    = owr_q;
endmodule
